[rtl/core/tdcpf_pkg.sv]
// Shared types, register map and arithmetic helpers for the temporal dot-crawl pixel filter.
// Used by tdcpf_pos_ctr, tdcpf_filter and temporal_dot_crawl_pixel_filter_unit; no dependencies.
package tdcpf_pkg;

	localparam int PIX_W = 16;
	localparam int SUM_W = PIX_W + 1;

	// Register indexes on the configuration port
	typedef enum logic [2:0] {
		CFG_SPATIAL_LIMIT   = 3'd0,
		CFG_LUMA_TEMP_LIMIT = 3'd1,
		CFG_CHROMA_SIMILAR  = 3'd2,
		CFG_CHROMA_CHANGE   = 3'd3,
		CFG_SAMPLE_BITS     = 3'd4,
		CFG_PLANE_CHROMA    = 3'd5,
		CFG_FRAME_WIDTH     = 3'd6,
		CFG_FRAME_HEIGHT    = 3'd7
	} cfg_idx_t;

	localparam int CFG_DATA_W = 13;

	typedef struct packed {
		logic [8:0]  spatial_limit;
		logic [7:0]  luma_temporal_limit;
		logic [7:0]  chroma_similar_limit;
		logic [7:0]  chroma_change_limit;
		logic [4:0]  sample_bits;
		logic        plane_is_chroma;
		logic [12:0] frame_width;
		logic [12:0] frame_height;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		spatial_limit:        9'd20,
		luma_temporal_limit:  8'd20,
		chroma_similar_limit: 8'd15,
		chroma_change_limit:  8'd5,
		sample_bits:          5'd8,
		plane_is_chroma:      1'b0,
		frame_width:          13'd720,
		frame_height:         13'd480
	};

	// Values that switch a rule off, and the sample width range
	localparam logic [8:0] SPATIAL_OFF = 9'd510;
	localparam logic [7:0] CHROMA_OFF  = 8'd255;
	localparam logic [4:0] BITS_MIN    = 5'd8;
	localparam logic [4:0] BITS_MAX    = 5'd16;

	typedef struct packed {
		logic [PIX_W-1:0] cur;
		logic [PIX_W-1:0] left;
		logic [PIX_W-1:0] right;
		logic [PIX_W-1:0] up2;
		logic [PIX_W-1:0] down2;
		logic [PIX_W-1:0] back2;
		logic [PIX_W-1:0] back1;
		logic [PIX_W-1:0] fwd1;
		logic [PIX_W-1:0] fwd2;
	} pix_t;

	// Position flags of one pixel, from the row and column counters
	typedef struct packed {
		logic border;
		logic frame_end;
	} pos_flags_t;

	function automatic logic [SUM_W-1:0] absdiff(input logic [SUM_W-1:0] a,
			input logic [SUM_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	// Rounded average of cur with the closer of prev and next; next wins a tie
	function automatic logic [PIX_W-1:0] blend_closer(input logic [PIX_W-1:0] prev,
			input logic [PIX_W-1:0] cur, input logic [PIX_W-1:0] next);
		logic [SUM_W-1:0] dp;
		logic [SUM_W-1:0] dn;
		logic [SUM_W-1:0] pick;
		logic [SUM_W:0]   sum;
		dp   = absdiff({1'b0, cur}, {1'b0, prev});
		dn   = absdiff({1'b0, cur}, {1'b0, next});
		pick = (dn <= dp) ? {1'b0, next} : {1'b0, prev};
		sum  = {1'b0, pick} + {2'b00, cur} + {{SUM_W{1'b0}}, 1'b1};
		return sum[PIX_W:1];
	endfunction

endpackage

[rtl/core/tdcpf_pos_ctr.sv]
// Raster position counters and border / end-of-plane flags for the pixel filter.
// Depends on tdcpf_pkg for the flag struct.
module tdcpf_pos_ctr #(
	parameter int MAX_DIM = 4096
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic [12:0]             frame_width,
	input  logic [12:0]             frame_height,
	output tdcpf_pkg::pos_flags_t   flags
);

	localparam int CNT_W = $clog2(MAX_DIM);
	localparam int EXT_W = ((CNT_W + 1 > 13) ? CNT_W + 1 : 13) + 1;
	localparam logic [EXT_W-1:0] DIM_MAX = EXT_W'(MAX_DIM);

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [EXT_W-1:0] w_ext, h_ext, w_cl, h_cl;
	logic [EXT_W-1:0] col_ext, row_ext;
	logic             last_col, last_row, border_row;

	// Clamp the plane size to 1..MAX_DIM
	assign w_ext = EXT_W'(frame_width);
	assign h_ext = EXT_W'(frame_height);
	assign w_cl  = (w_ext == '0) ? EXT_W'(1) : ((w_ext > DIM_MAX) ? DIM_MAX : w_ext);
	assign h_cl  = (h_ext == '0) ? EXT_W'(1) : ((h_ext > DIM_MAX) ? DIM_MAX : h_ext);

	// Locate the current pixel; counters past a shrunk size still end the row / plane
	assign col_ext    = EXT_W'(col_q);
	assign row_ext    = EXT_W'(row_q);
	assign last_col   = col_ext >= (w_cl - EXT_W'(1));
	assign last_row   = row_ext >= (h_cl - EXT_W'(1));
	assign border_row = (row_ext < EXT_W'(2)) || ((row_ext + EXT_W'(2)) >= h_cl);

	assign flags.border    = border_row || (col_q == '0) || last_col;
	assign flags.frame_end = last_col && last_row;

	// Advance on every input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

endmodule

[rtl/core/tdcpf_filter.sv]
// Per-pixel decision and blend for luma and chroma planes, purely combinational.
// Depends on tdcpf_pkg for the pixel and register structs and the helpers.
module tdcpf_filter (
	input  tdcpf_pkg::pix_t                 px,
	input  logic                            border,
	input  tdcpf_pkg::cfg_t                 cfg,
	output logic [tdcpf_pkg::PIX_W-1:0]     result
);

	localparam int SW = tdcpf_pkg::SUM_W;

	logic [4:0]    bits;
	logic [3:0]    sh;
	logic [SW-1:0] t_sim, t_chg, t_luma, t_spat;
	logic [SW-1:0] d_pn, d_cpp, d_cnn, d_cp, d_cn, d_h, d_v;
	logic [SW-1:0] cur2;
	logic          temporal_luma, temporal_chroma, chroma_hit, luma_hit;
	logic [tdcpf_pkg::PIX_W-1:0] blended;

	// Scale the limits, given for 8-bit samples, to the sample width
	assign bits = (cfg.sample_bits < tdcpf_pkg::BITS_MIN) ? tdcpf_pkg::BITS_MIN :
		((cfg.sample_bits > tdcpf_pkg::BITS_MAX) ? tdcpf_pkg::BITS_MAX : cfg.sample_bits);
	assign sh     = 4'(bits - tdcpf_pkg::BITS_MIN);
	assign t_sim  = SW'(cfg.chroma_similar_limit) << sh;
	assign t_chg  = SW'(cfg.chroma_change_limit) << sh;
	assign t_luma = SW'(cfg.luma_temporal_limit) << sh;
	assign t_spat = SW'(cfg.spatial_limit) << sh;

	// Temporal and spatial differences
	assign cur2  = {px.cur, 1'b0};
	assign d_pn  = tdcpf_pkg::absdiff({1'b0, px.back1}, {1'b0, px.fwd1});
	assign d_cpp = tdcpf_pkg::absdiff({1'b0, px.cur}, {1'b0, px.back2});
	assign d_cnn = tdcpf_pkg::absdiff({1'b0, px.cur}, {1'b0, px.fwd2});
	assign d_cp  = tdcpf_pkg::absdiff({1'b0, px.cur}, {1'b0, px.back1});
	assign d_cn  = tdcpf_pkg::absdiff({1'b0, px.cur}, {1'b0, px.fwd1});
	assign d_h   = tdcpf_pkg::absdiff({1'b0, px.left} + {1'b0, px.right}, cur2);
	assign d_v   = tdcpf_pkg::absdiff({1'b0, px.up2} + {1'b0, px.down2}, cur2);

	// Decide whether to replace the pixel
	assign temporal_luma   = (d_pn <= t_luma) && (d_cpp <= t_luma) && (d_cnn <= t_luma);
	assign temporal_chroma = (d_pn <= t_sim) && (d_cpp <= t_sim) && (d_cnn <= t_sim);
	assign chroma_hit = (cfg.chroma_change_limit < tdcpf_pkg::CHROMA_OFF) && temporal_chroma &&
		(d_cp > t_chg) && (d_cn > t_chg);
	assign luma_hit = !border && (cfg.spatial_limit < tdcpf_pkg::SPATIAL_OFF) &&
		(cfg.luma_temporal_limit != 8'd0) && ((d_h > t_spat) || (d_v > t_spat)) &&
		temporal_luma;

	assign blended = tdcpf_pkg::blend_closer(px.back1, px.cur, px.fwd1);
	assign result  = (cfg.plane_is_chroma ? chroma_hit : luma_hit) ? blended : px.cur;

endmodule

[rtl/core/temporal_dot_crawl_pixel_filter_unit.sv]
// Top level of the temporal dot-crawl pixel filter: register file, two-stage pipeline.
// Depends on tdcpf_pkg, tdcpf_pos_ctr and tdcpf_filter.
//
//   channel   handshake             payload
//   input     in_valid / in_stall   cur_pixel .. fwd_two_pixel, 9 x 16 bits
//   output    out_valid / out_stall out_pixel (16), frame_end (1)
//   config    cfg_valid / cfg_ready cfg_index (3), cfg_data (13)
//
// One pixel per cycle sustained while out_stall is low; a pixel passes the input register, then the result register.
// The per-pixel rule sits between the input stage and the result stage.
// Reset restores register defaults and returns the raster position to row 0, column 0.
// An output stall holds the result; the input stage keeps taking pixels until both
// stages are full. cfg_ready is always high.
module temporal_dot_crawl_pixel_filter_unit #(
	parameter int MAX_DIM = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [15:0]                       cur_pixel,
	input  logic [15:0]                       left_pixel,
	input  logic [15:0]                       right_pixel,
	input  logic [15:0]                       up_two_pixel,
	input  logic [15:0]                       down_two_pixel,
	input  logic [15:0]                       back_two_pixel,
	input  logic [15:0]                       back_one_pixel,
	input  logic [15:0]                       fwd_one_pixel,
	input  logic [15:0]                       fwd_two_pixel,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [15:0]                       out_pixel,
	output logic                              frame_end,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [2:0]                        cfg_index,
	input  logic [tdcpf_pkg::CFG_DATA_W-1:0]  cfg_data
);

	tdcpf_pkg::cfg_t       cfg_q;
	tdcpf_pkg::pos_flags_t pos_flags;
	tdcpf_pkg::pix_t       px_in;
	tdcpf_pkg::pix_t       px_s1;
	tdcpf_pkg::pos_flags_t flags_s1;
	logic                  valid_s1, valid_s2;
	logic [15:0]           pixel_s2;
	logic                  frame_end_s2;
	logic [15:0]           filt_result;
	logic                  in_xfer, adv_s1, adv_s2;

	// Register file
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= tdcpf_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (tdcpf_pkg::cfg_idx_t'(cfg_index))
				tdcpf_pkg::CFG_SPATIAL_LIMIT:   cfg_q.spatial_limit <= cfg_data[8:0];
				tdcpf_pkg::CFG_LUMA_TEMP_LIMIT: cfg_q.luma_temporal_limit <= cfg_data[7:0];
				tdcpf_pkg::CFG_CHROMA_SIMILAR:  cfg_q.chroma_similar_limit <= cfg_data[7:0];
				tdcpf_pkg::CFG_CHROMA_CHANGE:   cfg_q.chroma_change_limit <= cfg_data[7:0];
				tdcpf_pkg::CFG_SAMPLE_BITS:     cfg_q.sample_bits <= cfg_data[4:0];
				tdcpf_pkg::CFG_PLANE_CHROMA:    cfg_q.plane_is_chroma <= cfg_data[0];
				tdcpf_pkg::CFG_FRAME_WIDTH:     cfg_q.frame_width <= cfg_data[12:0];
				tdcpf_pkg::CFG_FRAME_HEIGHT:    cfg_q.frame_height <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// Pipeline flow control
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;
	assign in_xfer  = in_valid && !in_stall;

	tdcpf_pos_ctr #(
		.MAX_DIM(MAX_DIM)
	) u_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (in_xfer),
		.frame_width  (cfg_q.frame_width),
		.frame_height (cfg_q.frame_height),
		.flags        (pos_flags)
	);

	assign px_in = '{
		cur:   cur_pixel,
		left:  left_pixel,
		right: right_pixel,
		up2:   up_two_pixel,
		down2: down_two_pixel,
		back2: back_two_pixel,
		back1: back_one_pixel,
		fwd1:  fwd_one_pixel,
		fwd2:  fwd_two_pixel
	};

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Capture the input transfer with its position flags
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			px_s1    <= px_in;
			flags_s1 <= pos_flags;
		end
	end

	tdcpf_filter u_filter (
		.px     (px_s1),
		.border (flags_s1.border),
		.cfg    (cfg_q),
		.result (filt_result)
	);

	// Hold the result until the output transfer
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			pixel_s2     <= filt_result;
			frame_end_s2 <= flags_s1.frame_end;
		end
	end

	assign out_valid = valid_s2;
	assign out_pixel = pixel_s2;
	assign frame_end = frame_end_s2;

	// Stall at the input only when both stages hold an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled with a free pipeline stage");

	// A blocked result stage must freeze the input stage
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(px_s1) && $stable(flags_s1)))
		else $error("input stage changed while the result stage was blocked");

	// Luma border pixels pass unchanged
	a_border_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2 && flags_s1.border && !cfg_q.plane_is_chroma)
		|=> (out_pixel == $past(px_s1.cur)))
		else $error("luma border pixel was modified");

	// A plane ends only on a border pixel position (the last column)
	a_end_border: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && pos_flags.frame_end) |-> pos_flags.border)
		else $error("end of plane flagged away from the last column");

endmodule
